>>> rtl/core/default_route_selector_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the default route selector
// Clocked implication checks with an asynchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef DEFAULT_ROUTE_SELECTOR_UNIT_ASSERT_SVH
`define DEFAULT_ROUTE_SELECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define DRS_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/drs_pkg.sv
// ---------------------------------------------------------------------------
// drs_pkg
// Shared types and constants of the default route selector.
// ---------------------------------------------------------------------------
package drs_pkg;

	localparam int unsigned NUM_LINKS   = 3;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned IFACE_IN_W  = 3;
	localparam int unsigned ADDR_W      = 32;
	localparam int unsigned RSSI_W      = 8;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned CNT_W       = 32;

	typedef enum logic [1:0] {
		IF_NONE   = 2'd0,
		IF_WIFI   = 2'd1,
		IF_ETH    = 2'd2,
		IF_THREAD = 2'd3
	} iface_t;

	typedef enum logic [1:0] {
		EDGE_NONE    = 2'd0,
		EDGE_UP      = 2'd1,
		EDGE_DOWN    = 2'd2,
		EDGE_CHANGED = 2'd3
	} route_edge_t;

	typedef struct packed {
		logic [ADDR_W-1:0]        ip;
		logic [ADDR_W-1:0]        mask;
		logic [ADDR_W-1:0]        gateway;
		logic signed [RSSI_W-1:0] rssi;
	} link_rec_t;

	// classified report, as held in the queue
	typedef struct packed {
		logic              known;
		iface_t            ifc;
		logic              up;
		link_rec_t         rec;
		logic [TIME_W-1:0] now;
	} job_t;

	typedef struct packed {
		route_edge_t              edge_res;
		logic                     record_changed;
		iface_t                   active_iface;
		logic                     route_up;
		logic [CNT_W-1:0]         route_count;
		logic [ADDR_W-1:0]        active_ip;
		logic [ADDR_W-1:0]        active_mask;
		logic [ADDR_W-1:0]        active_gateway;
		logic signed [RSSI_W-1:0] active_rssi;
		logic [TIME_W-1:0]        route_age_ms;
	} result_t;

endpackage

>>> rtl/core/drs_if.sv
// ---------------------------------------------------------------------------
// drs_report_if / drs_result_if
// Valid/ready channels carrying link reports and route status words.
// ---------------------------------------------------------------------------
interface drs_report_if;
	logic                                valid;
	logic                                ready;
	logic [drs_pkg::IFACE_IN_W-1:0]      iface;
	logic                                link_up;
	logic [drs_pkg::ADDR_W-1:0]          ip_addr;
	logic [drs_pkg::ADDR_W-1:0]          net_mask;
	logic [drs_pkg::ADDR_W-1:0]          gateway_addr;
	logic signed [drs_pkg::RSSI_W-1:0]   signal_rssi;
	logic [drs_pkg::TIME_W-1:0]          now_ms;

	modport source (output valid, iface, link_up, ip_addr, net_mask, gateway_addr,
		signal_rssi, now_ms, input ready);
	modport sink (input valid, iface, link_up, ip_addr, net_mask, gateway_addr,
		signal_rssi, now_ms, output ready);
endinterface

interface drs_result_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          edge_res;
	logic                                record_changed;
	logic [1:0]                          active_iface;
	logic                                route_up;
	logic [drs_pkg::CNT_W-1:0]           route_count;
	logic [drs_pkg::ADDR_W-1:0]          active_ip;
	logic [drs_pkg::ADDR_W-1:0]          active_mask;
	logic [drs_pkg::ADDR_W-1:0]          active_gateway;
	logic signed [drs_pkg::RSSI_W-1:0]   active_rssi;
	logic [drs_pkg::TIME_W-1:0]          route_age_ms;

	modport source (output valid, edge_res, record_changed, active_iface, route_up,
		route_count, active_ip, active_mask, active_gateway, active_rssi, route_age_ms,
		input ready);
	modport sink (input valid, edge_res, record_changed, active_iface, route_up,
		route_count, active_ip, active_mask, active_gateway, active_rssi, route_age_ms,
		output ready);
endinterface

>>> rtl/core/drs_front.sv
// ---------------------------------------------------------------------------
// drs_front
// Classifies a report word: interface check, down-link zeroing.
// ---------------------------------------------------------------------------
module drs_front (
	drs_report_if.sink       report,
	output drs_pkg::job_t    job,
	output logic             job_valid,
	input  logic             job_ready
);

	always_comb begin
		job.known = (report.iface[drs_pkg::IFACE_IN_W-1] == 1'b0) &&
			(drs_pkg::iface_t'(report.iface[1:0]) != drs_pkg::IF_NONE);
		job.ifc   = drs_pkg::iface_t'(report.iface[1:0]);
		job.up    = report.link_up;
		job.now   = report.now_ms;
		if (report.link_up) begin
			job.rec.ip      = report.ip_addr;
			job.rec.mask    = report.net_mask;
			job.rec.gateway = report.gateway_addr;
			job.rec.rssi    = report.signal_rssi;
		end else begin
			job.rec = '0;
		end
	end

	assign job_valid    = report.valid;
	assign report.ready = job_ready;

endmodule

>>> rtl/core/drs_queue.sv
// ---------------------------------------------------------------------------
// drs_queue
// Small FIFO of classified reports between front and back.
// ---------------------------------------------------------------------------
`include "default_route_selector_unit_assert.svh"

module drs_queue #(
	parameter int unsigned Depth = drs_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  drs_pkg::job_t push_data,
	input  logic          push_valid,
	output logic          push_ready,
	output drs_pkg::job_t pop_data,
	output logic          pop_valid,
	input  logic          pop_ready
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	drs_pkg::job_t    mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	`DRS_ASSERT_NEXT(a_cnt_inc, clk, arst_n, push && !pop, count_q == $past(count_q) + CntW'(1), "queue count did not grow on push")
	`DRS_ASSERT_NEXT(a_cnt_dec, clk, arst_n, pop && !push, count_q == $past(count_q) - CntW'(1), "queue count did not shrink on pop")
	`DRS_ASSERT_IMPLIES(a_empty_ptrs, clk, arst_n, count_q == '0, rd_ptr_q == wr_ptr_q, "empty queue with pointers apart")

endmodule

>>> rtl/core/drs_back.sv
// ---------------------------------------------------------------------------
// drs_back
// Link records, route selection, edge logic and the result register.
// ---------------------------------------------------------------------------
`include "default_route_selector_unit_assert.svh"

module drs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  drs_pkg::job_t job,
	input  logic          job_valid,
	output logic          job_ready,
	drs_result_if.source  result
);

	logic                              flag_q [drs_pkg::NUM_LINKS];
	drs_pkg::link_rec_t                rec_q  [drs_pkg::NUM_LINKS];
	drs_pkg::iface_t                   cur_q;
	logic [drs_pkg::CNT_W-1:0]         count_q;
	logic [drs_pkg::TIME_W-1:0]        start_q;
	drs_pkg::result_t                  res_q;
	logic                              res_valid_q;

	logic                              flag_n [drs_pkg::NUM_LINKS];
	drs_pkg::link_rec_t                rec_n  [drs_pkg::NUM_LINKS];
	logic [drs_pkg::NUM_LINKS-1:0]     hit;
	logic [drs_pkg::NUM_LINKS-1:0]     route_eq;
	logic [drs_pkg::NUM_LINKS-1:0]     full_eq;
	logic                              addr_match;
	logic                              rewrite;
	drs_pkg::iface_t                   sel;
	drs_pkg::iface_t                   cur_n;
	drs_pkg::route_edge_t              edge_n;
	logic [drs_pkg::CNT_W-1:0]         count_n;
	logic [drs_pkg::TIME_W-1:0]        start_n;
	drs_pkg::link_rec_t                act;
	drs_pkg::result_t                  res_n;
	logic                              accept;

	assign job_ready = !res_valid_q || result.ready;
	assign accept    = job_valid && job_ready;

	// per-link compare against the incoming record
	always_comb begin
		for (int k = 0; k < drs_pkg::NUM_LINKS; k++) begin
			hit[k]      = job.known && (job.ifc == drs_pkg::iface_t'(2'(k + 1)));
			route_eq[k] = (flag_q[k] == job.up) && (rec_q[k].ip == job.rec.ip) &&
				(rec_q[k].mask == job.rec.mask) && (rec_q[k].gateway == job.rec.gateway);
			full_eq[k]  = route_eq[k] && (rec_q[k].rssi == job.rec.rssi);
		end
		addr_match = |(hit & route_eq);
		rewrite    = |(hit & ~full_eq);
		for (int k = 0; k < drs_pkg::NUM_LINKS; k++) begin
			flag_n[k] = (hit[k] && rewrite) ? job.up : flag_q[k];
			rec_n[k]  = (hit[k] && rewrite) ? job.rec : rec_q[k];
		end
	end

	// fixed preference: ethernet, wifi station, thread
	always_comb begin
		if (flag_n[2'(drs_pkg::IF_ETH) - 2'd1]) begin
			sel = drs_pkg::IF_ETH;
		end else if (flag_n[2'(drs_pkg::IF_WIFI) - 2'd1]) begin
			sel = drs_pkg::IF_WIFI;
		end else if (flag_n[2'(drs_pkg::IF_THREAD) - 2'd1]) begin
			sel = drs_pkg::IF_THREAD;
		end else begin
			sel = drs_pkg::IF_NONE;
		end
	end

	always_comb begin
		edge_n  = drs_pkg::EDGE_NONE;
		cur_n   = cur_q;
		count_n = count_q;
		start_n = start_q;
		if (rewrite) begin
			if (cur_q == drs_pkg::IF_NONE && sel != drs_pkg::IF_NONE) begin
				edge_n  = drs_pkg::EDGE_UP;
				cur_n   = sel;
				count_n = count_q + 1'b1;
				start_n = job.now;
			end else if (cur_q != drs_pkg::IF_NONE && sel == drs_pkg::IF_NONE) begin
				edge_n  = drs_pkg::EDGE_DOWN;
				cur_n   = drs_pkg::IF_NONE;
				start_n = '0;
			end else if (cur_q != sel) begin
				edge_n  = drs_pkg::EDGE_CHANGED;
				cur_n   = sel;
				count_n = count_q + 1'b1;
				start_n = job.now;
			end else if (job.ifc == cur_q && !addr_match) begin
				// active link got a new address set
				edge_n  = drs_pkg::EDGE_CHANGED;
				count_n = count_q + 1'b1;
				start_n = job.now;
			end
		end
	end

	// status of the route after this word
	always_comb begin
		act = '0;
		for (int k = 0; k < drs_pkg::NUM_LINKS; k++) begin
			if (cur_n == drs_pkg::iface_t'(2'(k + 1))) begin
				act = rec_n[k];
			end
		end
		res_n.edge_res       = edge_n;
		res_n.record_changed = rewrite;
		res_n.active_iface   = cur_n;
		res_n.route_up       = (cur_n != drs_pkg::IF_NONE);
		res_n.route_count    = count_n;
		res_n.active_ip      = act.ip;
		res_n.active_mask    = act.mask;
		res_n.active_gateway = act.gateway;
		res_n.active_rssi    = (cur_n == drs_pkg::IF_WIFI) ? act.rssi : '0;
		res_n.route_age_ms   = res_n.route_up ? (job.now - start_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < drs_pkg::NUM_LINKS; k++) begin
				flag_q[k] <= 1'b0;
				rec_q[k]  <= '0;
			end
			cur_q       <= drs_pkg::IF_NONE;
			count_q     <= '0;
			start_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				for (int k = 0; k < drs_pkg::NUM_LINKS; k++) begin
					flag_q[k] <= flag_n[k];
					rec_q[k]  <= rec_n[k];
				end
				cur_q       <= cur_n;
				count_q     <= count_n;
				start_q     <= start_n;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_n;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.edge_res       = res_q.edge_res;
	assign result.record_changed = res_q.record_changed;
	assign result.active_iface   = res_q.active_iface;
	assign result.route_up       = res_q.route_up;
	assign result.route_count    = res_q.route_count;
	assign result.active_ip      = res_q.active_ip;
	assign result.active_mask    = res_q.active_mask;
	assign result.active_gateway = res_q.active_gateway;
	assign result.active_rssi    = res_q.active_rssi;
	assign result.route_age_ms   = res_q.route_age_ms;

	`DRS_ASSERT_IMPLIES(a_up_has_route, clk, arst_n, res_valid_q && res_q.edge_res == drs_pkg::EDGE_UP, res_q.route_up && res_q.route_age_ms == '0, "up edge without fresh route")
	`DRS_ASSERT_IMPLIES(a_down_no_route, clk, arst_n, res_valid_q && res_q.edge_res == drs_pkg::EDGE_DOWN, !res_q.route_up && res_q.active_iface == drs_pkg::IF_NONE, "down edge with route left")
	`DRS_ASSERT_IMPLIES(a_edge_rewrite, clk, arst_n, res_valid_q && res_q.edge_res != drs_pkg::EDGE_NONE, res_q.record_changed, "edge without record rewrite")

endmodule

>>> rtl/core/default_route_selector_unit.sv
// ---------------------------------------------------------------------------
// default_route_selector_unit
// Link report tracker with fixed-preference default route selection.
// ---------------------------------------------------------------------------
// Takes one link report word per cycle while the FIFO has room and returns one
// status word per report, in order. A report is classified in the front
// (interface check, down links zeroed), waits in a short FIFO, and is applied in
// the back: the record compare, the ethernet/wifi/thread preference, the edge
// decision, the route counter and the route age are all combinational ahead of
// the result register, so sustained throughput is one report per clock while
// each status word is taken. A report passes the FIFO storage, then the output
// register, where its status word waits while the FIFO keeps taking reports
// until it holds QueueDepth of them. Reports for interface codes other than wifi
// station, ethernet and thread leave all state alone and echo the current route.
module default_route_selector_unit #(
	parameter int unsigned QueueDepth = drs_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	drs_report_if.sink   report,
	drs_result_if.source result
);

	// front -> queue
	drs_pkg::job_t front_job;
	logic          front_valid;
	logic          front_ready;

	// queue -> back
	drs_pkg::job_t back_job;
	logic          back_valid;
	logic          back_ready;

	drs_front u_front (
		.report    (report),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	drs_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_job),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (back_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	// records, selection and the result register
	drs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (back_job),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.result    (result)
	);

endmodule
